### design/lbs_pkg.sv
// Shared types and constants for the linear blend skinning block.
// Used by the front end, the command queue, the back end and the top level.
package lbs_pkg;

  localparam int JOINT_COUNT = 32;
  localparam int JW = $clog2(JOINT_COUNT);
  localparam int MAT_WORDS = 12;
  localparam int MEM_DEPTH = JOINT_COUNT * MAT_WORDS;
  localparam int AW = $clog2(MEM_DEPTH);
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [1:0] OP_BIND = 2'd0;
  localparam logic [1:0] OP_POSE = 2'd1;
  localparam logic [1:0] OP_VERT = 2'd2;

  typedef struct packed {
    logic             valid;
    logic             mat_sel;
    logic [AW-1:0]    addr;
    logic [31:0]      data;
  } mem_wr_t;

  // A load command carries its element address in base and its value in vx.
  typedef struct packed {
    logic             is_load;
    logic             mat_sel;
    logic             has_term;
    logic             last;
    logic [AW-1:0]    base;
    logic [31:0]      vx;
    logic [31:0]      vy;
    logic [31:0]      vz;
    logic [16:0]      weight;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

endpackage

### design/lbs_front.sv
// Front end: classifies input items and issues matrix loads and vertex commands.
// Depends on lbs_pkg.
module lbs_front import lbs_pkg::*; (
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_op,
  input  logic [4:0]  in_joint,
  input  logic [1:0]  in_row,
  input  logic [1:0]  in_col,
  input  logic [31:0] in_value,
  input  logic [31:0] in_vx,
  input  logic [31:0] in_vy,
  input  logic [31:0] in_vz,
  input  logic [16:0] in_weight,
  input  logic        in_last,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic xfer;
  logic in_range;
  logic is_load;
  logic [AW-1:0] base;

  assign in_full  = q_full;
  assign xfer     = in_push && !q_full;
  assign in_range = ({3'd0, in_joint} < 8'(JOINT_COUNT));
  assign base     = AW'(in_joint) * AW'(MAT_WORDS);
  assign is_load  = (in_op == OP_BIND || in_op == OP_POSE);

  // Loads travel through the queue as well, so a matrix write never overtakes
  // a vertex term that was accepted before it.
  always_comb begin
    q_push         = xfer && ((is_load && in_range && (in_row != 2'd3)) ||
                              ((in_op == OP_VERT) && (in_range || in_last)));
    q_cmd.is_load  = is_load;
    q_cmd.mat_sel  = (in_op == OP_POSE);
    q_cmd.has_term = in_range;
    q_cmd.last     = in_last;
    q_cmd.base     = is_load ? base + AW'({in_row, in_col}) : base;
    q_cmd.vx       = is_load ? in_value : in_vx;
    q_cmd.vy       = in_vy;
    q_cmd.vz       = in_vz;
    q_cmd.weight   = in_weight;
  end

endmodule

### design/lbs_queue.sv
// Short command queue between the front end and the back end.
// Depends on lbs_pkg.
module lbs_queue import lbs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t dout
);

  cmd_t mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= din;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + 1'b1;
      if (pop && !empty) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push && !full) - (QAW+1)'(pop && !empty);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    full |=> !(empty));
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= (QAW+1)'(QDEPTH))) else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (empty && !push) |=> empty) else $error("queue filled without transfer");

endmodule

### design/lbs_back.sv
// Back end: matrix memories, shared multiplier sequencer, accumulator, result register.
// Depends on lbs_pkg.
module lbs_back import lbs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  output logic        out_clipped
);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_MUL, S_SUM, S_WGT, S_ACC, S_OUT} state_t;

  localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

  logic [31:0] bind_mem [MEM_DEPTH];
  logic [31:0] pose_mem [MEM_DEPTH];
  logic [31:0] rd_r;

  state_t state_r;
  cmd_t cmd_r;
  mem_wr_t wr;
  logic pass_r;            // 0 bind pass, 1 pose pass
  logic [1:0] row_r, col_r, k_r;
  logic signed [31:0] p_r [3];
  logic signed [31:0] q_r [3];
  logic signed [48:0] s_r;
  logic signed [63:0] prod_r;
  logic signed [47:0] acc_r [3];
  logic [31:0] ox_r, oy_r, oz_r;
  logic oc_r, full_r;

  always_comb begin
    wr.valid   = q_pop && q_cmd.is_load;
    wr.mat_sel = q_cmd.mat_sel;
    wr.addr    = q_cmd.base;
    wr.data    = q_cmd.vx;
  end

  // Memory writes and a single registered read port per memory.
  logic [AW-1:0] raddr;
  assign raddr = cmd_r.base + AW'({row_r, col_r});
  always_ff @(posedge clk) begin
    if (wr.valid && !wr.mat_sel) bind_mem[wr.addr] <= wr.data;
    if (wr.valid &&  wr.mat_sel) pose_mem[wr.addr] <= wr.data;
    rd_r <= pass_r ? pose_mem[raddr] : bind_mem[raddr];
  end

  function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
    if (x > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -48'sh0000_8000_0000) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] sat_row(input logic signed [48:0] x);
    if (x > 49'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -49'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  logic signed [31:0] mop;
  logic signed [47:0] rnd;
  logic signed [48:0] row_sum;
  logic signed [48:0] accs;
  logic signed [47:0] wterm;
  assign mop     = (col_r == 2'd3) ? 32'sd0 : p_r[col_r[1:0] == 2'd3 ? 2'd0 : col_r];
  assign rnd     = 48'((prod_r + 64'sd32768) >>> 16);
  assign wterm   = 48'((prod_r + 64'sd32768) >>> 16);
  assign row_sum = s_r + 49'(rnd);
  assign accs    = 49'(acc_r[k_r]) + 49'(wterm);

  logic hitx, hity, hitz;
  assign hitx = (sat32(acc_r[0]) != acc_r[0][31:0]) || (acc_r[0] != 48'(sat32(acc_r[0])));
  assign hity = (acc_r[1] != 48'(sat32(acc_r[1])));
  assign hitz = (acc_r[2] != 48'(sat32(acc_r[2])));

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign out_empty = !full_r;
  assign out_x = ox_r;
  assign out_y = oy_r;
  assign out_z = oz_r;
  assign out_clipped = oc_r;

  // Per element: S_RD issues the read, S_MUL multiplies, S_SUM rounds and adds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      full_r  <= 1'b0;
      for (int i = 0; i < 3; i++) acc_r[i] <= '0;
      pass_r <= 1'b0; row_r <= '0; col_r <= '0; k_r <= '0;
    end else begin
      if (full_r && out_pop) full_r <= 1'b0;
      case (state_r)
        S_IDLE: if (q_pop) begin
          cmd_r   <= q_cmd;
          p_r[0]  <= q_cmd.vx; p_r[1] <= q_cmd.vy; p_r[2] <= q_cmd.vz;
          pass_r  <= 1'b0; row_r <= '0; col_r <= '0; k_r <= '0;
          state_r <= q_cmd.is_load ? S_IDLE : (q_cmd.has_term ? S_RD : S_OUT);
        end
        S_RD: begin
          state_r <= S_MUL;
          if (col_r == 2'd0) s_r <= '0;
        end
        S_MUL: begin
          if (col_r == 2'd3) prod_r <= 64'(signed'(rd_r)) <<< 16;
          else prod_r <= 64'(signed'(rd_r)) * 64'(mop);
          state_r <= S_SUM;
        end
        S_SUM: begin
          if (col_r != 2'd3) begin
            s_r <= row_sum;
            col_r <= col_r + 1'b1;
            state_r <= S_RD;
          end else begin
            q_r[row_r] <= sat_row(row_sum);
            col_r <= '0;
            if (row_r != 2'd2) begin
              row_r <= row_r + 1'b1;
              state_r <= S_RD;
            end else begin
              row_r <= '0;
              if (!pass_r) begin
                pass_r <= 1'b1;
                p_r[0] <= sat32(48'(q_r[0])); p_r[1] <= sat32(48'(q_r[1]));
                p_r[2] <= sat_row(row_sum);
                state_r <= S_RD;
              end else begin
                state_r <= S_WGT;
              end
            end
          end
        end
        S_WGT: begin
          prod_r  <= 64'(q_r[k_r]) * signed'({47'd0, cmd_r.weight});
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (accs > 49'(ACC_MAX)) acc_r[k_r] <= ACC_MAX;
          else if (accs < 49'(ACC_MIN)) acc_r[k_r] <= ACC_MIN;
          else acc_r[k_r] <= accs[47:0];
          if (k_r != 2'd2) begin
            k_r <= k_r + 1'b1;
            state_r <= S_WGT;
          end else begin
            k_r <= '0;
            state_r <= cmd_r.last ? S_OUT : S_IDLE;
          end
        end
        S_OUT: if (!full_r) begin
          ox_r <= sat32(acc_r[0]); oy_r <= sat32(acc_r[1]); oz_r <= sat32(acc_r[2]);
          oc_r <= hitx || hity || hitz;
          full_r <= 1'b1;
          for (int i = 0; i < 3; i++) acc_r[i] <= '0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (full_r && !out_pop) |=> full_r) else $error("result lost");
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE)) else $error("pop while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !full_r) |=> (full_r && acc_r[0] == '0)) else $error("emit");

endmodule

### design/linear_blend_skinning.sv
// Linear blend skinning top level: front end, command queue, back end.
// A vertex term runs 24 matrix elements through the back end (read, multiply, round and add
// on one shared multiplier), then three weight multiplies. A last term then passes through
// S_OUT, which registers the result once the previous result has been popped. A load is
// written to its matrix as the back end takes it from the queue. Synchronous active-low
// reset clears control state and accumulators; matrices are undefined until written.
module linear_blend_skinning import lbs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_op,
  input  logic [4:0]  in_joint,
  input  logic [1:0]  in_row,
  input  logic [1:0]  in_col,
  input  logic [31:0] in_value,
  input  logic [31:0] in_vx,
  input  logic [31:0] in_vy,
  input  logic [31:0] in_vz,
  input  logic [16:0] in_weight,
  input  logic        in_last,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  output logic        out_clipped
);

  logic q_full, q_push, q_pop, q_empty;
  cmd_t q_in, q_out;

  lbs_front u_front (
    .in_push, .in_full, .in_op, .in_joint, .in_row, .in_col,
    .in_value, .in_vx, .in_vy, .in_vz, .in_weight, .in_last,
    .q_full, .q_push, .q_cmd(q_in)
  );

  lbs_queue u_queue (
    .clk, .rst_n, .push(q_push), .din(q_in), .full(q_full),
    .pop(q_pop), .empty(q_empty), .dout(q_out)
  );

  lbs_back u_back (
    .clk, .rst_n, .q_empty, .q_cmd(q_out), .q_pop,
    .out_empty, .out_pop, .out_x, .out_y, .out_z, .out_clipped
  );

endmodule

### tb/tb.sv
// Testbench for linear_blend_skinning: loads joint matrices, streams vertex terms
// and compares each skinned vertex with a Q16.16 predictor kept in this module.
// Depends on lbs_pkg and the linear_blend_skinning RTL.
module tb import lbs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam longint ACC_HI = 64'sd140737488355327;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint W_HI = 64'sd2147483647;
  localparam longint W_LO = -64'sd2147483648;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        clip;
  } vtx_t;

  typedef struct {
    logic [1:0]  op;
    logic [4:0]  joint;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] value;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [16:0] weight;
    logic        last;
    bit          typed;
    vtx_t        want;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_op = '0;
  logic [4:0]  in_joint = '0;
  logic [1:0]  in_row = '0;
  logic [1:0]  in_col = '0;
  logic [31:0] in_value = '0;
  logic [31:0] in_vx = '0;
  logic [31:0] in_vy = '0;
  logic [31:0] in_vz = '0;
  logic [16:0] in_weight = '0;
  logic        in_last = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic        out_clipped;

  int   bind_m [MEM_DEPTH];
  int   pose_m [MEM_DEPTH];
  longint acc_x, acc_y, acc_z;
  vtx_t skinned_q [$];
  stim_t dir_tab [$];
  int   errors = 0;
  bit   quiet = 1'b0;
  int   stall_cnt = 0;

  linear_blend_skinning i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  function automatic longint rnd16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi, inout bit hit);
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic void xform(bit use_pose, int base, longint p [3], output longint q [3]);
    longint s;
    bit     unused;
    for (int r = 0; r < 3; r++) begin
      s = longint'(use_pose ? pose_m[base + r*4 + 3] : bind_m[base + r*4 + 3]);
      for (int c = 0; c < 3; c++)
        s += rnd16(longint'(use_pose ? pose_m[base + r*4 + c] : bind_m[base + r*4 + c]) * p[c]);
      q[r] = sat(s, W_LO, W_HI, unused);
    end
  endfunction

  // Updates the predicted state for one accepted item; returns 1 when a vertex completes.
  function automatic bit skin_item(stim_t s, output vtx_t v);
    longint pt [3], pb [3], pq [3];
    int     base;
    bit     hit;
    v = '{default: '0};
    if (s.op == OP_BIND || s.op == OP_POSE) begin
      if (s.row != 2'd3) begin
        if (s.op == OP_BIND) bind_m[s.joint*MAT_WORDS + s.row*4 + s.col] = s.value;
        else pose_m[s.joint*MAT_WORDS + s.row*4 + s.col] = s.value;
      end
      return 1'b0;
    end
    if (s.op == OP_NONE) return 1'b0;
    base = s.joint * MAT_WORDS;
    pt[0] = longint'(signed'(s.vx));
    pt[1] = longint'(signed'(s.vy));
    pt[2] = longint'(signed'(s.vz));
    xform(1'b0, base, pt, pb);
    xform(1'b1, base, pb, pq);
    hit = 1'b0;
    acc_x = sat(acc_x + rnd16(longint'(s.weight) * pq[0]), ACC_LO, ACC_HI, hit);
    acc_y = sat(acc_y + rnd16(longint'(s.weight) * pq[1]), ACC_LO, ACC_HI, hit);
    acc_z = sat(acc_z + rnd16(longint'(s.weight) * pq[2]), ACC_LO, ACC_HI, hit);
    if (!s.last) return 1'b0;
    hit = 1'b0;
    v.x = 32'(sat(acc_x, W_LO, W_HI, hit));
    v.y = 32'(sat(acc_y, W_LO, W_HI, hit));
    v.z = 32'(sat(acc_z, W_LO, W_HI, hit));
    v.clip = hit;
    acc_x = 0;
    acc_y = 0;
    acc_z = 0;
    return 1'b1;
  endfunction

  function automatic stim_t load_row(logic [1:0] op, int j, int r, int c, logic [31:0] val,
                                     logic lst = 1'b0);
    stim_t s;
    s = '{default: '0};
    s.op = op;
    s.joint = 5'(j);
    s.row = 2'(r);
    s.col = 2'(c);
    s.value = val;
    s.vx = $urandom;
    s.last = lst;
    return s;
  endfunction

  function automatic stim_t vert_row(int j, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                     logic [16:0] w, logic lst);
    stim_t s;
    s = '{default: '0};
    s.op = OP_VERT;
    s.joint = 5'(j);
    s.vx = x;
    s.vy = y;
    s.vz = z;
    s.weight = w;
    s.last = lst;
    s.value = $urandom;
    return s;
  endfunction

  function automatic stim_t typed(stim_t s, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                  logic c);
    s.typed = 1'b1;
    s.want = '{x, y, z, c};
    return s;
  endfunction

  function automatic void add_row(stim_t s);
    dir_tab = {dir_tab, s};
  endfunction

  // Only joints 0 to 7, 30 and 31 get all their matrix entries loaded.
  function automatic int live_joint();
    int k;
    k = $urandom_range(0, 9);
    return (k < 8) ? k : k + 22;
  endfunction

  function automatic logic [31:0] coord(bit full_range);
    return full_range ? 32'($urandom) : 32'($urandom_range(0, 524288) - 262144);
  endfunction

  task automatic send(stim_t s);
    vtx_t v;
    @(negedge clk);
    in_op = s.op;
    in_joint = s.joint;
    in_row = s.row;
    in_col = s.col;
    in_value = s.value;
    in_vx = s.vx;
    in_vy = s.vy;
    in_vz = s.vz;
    in_weight = s.weight;
    in_last = s.last;
    in_push = 1'b1;
    do @(posedge clk); while (in_full);
    if (skin_item(s, v)) begin
      if (s.typed) v = s.want;
      skinned_q = {skinned_q, v};
    end
    if (!quiet && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_push = 1'b0;
      repeat ($urandom_range(0, 16)) @(negedge clk);
    end
  endtask

  // Result side: decide pop at the falling edge, check a transfer at the rising edge.
  always @(negedge clk) begin
    if (stall_cnt > 0) begin
      stall_cnt--;
      out_pop = 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_cnt = $urandom_range(0, 16);
      out_pop = 1'b0;
    end else begin
      out_pop = 1'b1;
    end
  end

  always @(posedge clk) begin
    vtx_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (skinned_q.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h clipped=%b", $time,
                 out_x, out_y, out_z, out_clipped);
        errors++;
      end else begin
        e = skinned_q.pop_front();
        if (out_x !== e.x) begin
          $display("%0t: out_x expected %h actual %h", $time, e.x, out_x);
          errors++;
        end
        if (out_y !== e.y) begin
          $display("%0t: out_y expected %h actual %h", $time, e.y, out_y);
          errors++;
        end
        if (out_z !== e.z) begin
          $display("%0t: out_z expected %h actual %h", $time, e.z, out_z);
          errors++;
        end
        if (out_clipped !== e.clip) begin
          $display("%0t: out_clipped expected %b actual %b", $time, e.clip, out_clipped);
          errors++;
        end
      end
    end
  end

  initial begin
    int    n_items;
    int    terms;
    int    sel;
    bit    wide;
    stim_t s;
    acc_x = 0;
    acc_y = 0;
    acc_z = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Every matrix entry of the joints that vertex terms use is written before any term
    // reads it; joint 0 is identity.
    for (int j = 0; j < JOINT_COUNT; j++)
      if (j < 8 || j >= 30)
        for (int m = 0; m < 2; m++)
          for (int r = 0; r < 3; r++)
            for (int c = 0; c < 4; c++) begin
              if (j == 0) s = load_row(m ? OP_POSE : OP_BIND, j, r, c,
                                       (r == c) ? 32'h10000 : 0);
              else if (c == 3) s = load_row(m ? OP_POSE : OP_BIND, j, r, c,
                                            32'($urandom_range(0, 13107200) - 6553600));
              else s = load_row(m ? OP_POSE : OP_BIND, j, r, c,
                                32'($urandom_range(0, 262144) - 131072));
              send(s);
            end

    add_row(typed(vert_row(0, 32'h10000, 32'h20000, 32'h30000, 17'h10000, 1),
                  32'h10000, 32'h20000, 32'h30000, 0));
    add_row(typed(vert_row(0, 32'h7fffffff, 32'h80000000, 0, 17'h10000, 1),
                  32'h7fffffff, 32'h80000000, 0, 0));
    add_row(vert_row(0, 32'h7fffffff, 0, 32'h80000000, 17'h10000, 0));
    add_row(typed(vert_row(0, 32'h7fffffff, 0, 32'h80000000, 17'h10000, 1),
                  32'h7fffffff, 0, 32'h80000000, 1));
    add_row(typed(vert_row(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 1),
                  0, 0, 0, 0));
    add_row(typed(vert_row(0, 32'h10000, 0, 0, 17'h1ffff, 1), 32'h1ffff, 0, 0, 0));
    // Half weight on one LSB: a tie rounds up, the negative tie lands on zero.
    add_row(typed(vert_row(0, 32'hffffffff, 32'h1, 0, 17'h8000, 1), 0, 1, 0, 0));
    // A load to the fixed bottom row is dropped, so joint 0 stays identity.
    add_row(load_row(OP_BIND, 0, 3, 0, 32'h12345));
    add_row(load_row(OP_POSE, 0, 3, 3, 32'hffffffff));
    add_row(typed(vert_row(0, 32'h50000, 0, 0, 17'h10000, 1), 32'h50000, 0, 0, 0));
    s = vert_row(0, 32'h10000, 0, 0, 17'h10000, 1);
    s.op = OP_NONE;
    add_row(s);
    add_row(load_row(OP_POSE, 31, 2, 3, 32'h7fffffff, 1));
    add_row(load_row(OP_BIND, 30, 0, 0, 32'h80000000, 1));
    add_row(vert_row(31, 32'h80000000, 32'h80000000, 32'h80000000, 17'h10000, 1));
    add_row(vert_row(30, 32'h7fffffff, 32'h12345, 32'hfffe0000, 17'h1ffff, 0));
    add_row(vert_row(31, 32'h30000, 32'hfffd0000, 32'h7fff0000, 17'h1ffff, 1));
    add_row(vert_row(5, 32'h18000, 32'h8000, 32'hffff8000, 17'h8000, 1));
    foreach (dir_tab[i]) send(dir_tab[i]);

    n_items = 0;
    while (n_items < 393) begin
      if (n_items > 340) quiet = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        terms = $urandom_range(1, 4);
        wide = ($urandom_range(0, 9) == 0);
        for (int t = 0; t < terms; t++) begin
          send(vert_row(live_joint(), coord(wide), coord(wide), coord(wide),
                        ($urandom_range(0, 4) == 0) ? 17'($urandom_range(0, 131071))
                                                    : 17'($urandom_range(0, 65536)),
                        t == terms - 1));
          n_items++;
        end
      end else if (sel < 92) begin
        wide = ($urandom_range(0, 5) == 0);
        s = load_row($urandom_range(0, 1) ? OP_POSE : OP_BIND, $urandom_range(0, 31),
                     ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2),
                     $urandom_range(0, 3),
                     wide ? 32'($urandom) : 32'($urandom_range(0, 262144) - 131072),
                     1'($urandom));
        s.weight = 17'($urandom);
        send(s);
        n_items++;
      end else begin
        s = vert_row($urandom_range(0, 31), $urandom, $urandom, $urandom, 17'($urandom),
                     1'($urandom));
        s.op = OP_NONE;
        s.row = 2'($urandom);
        s.col = 2'($urandom);
        send(s);
        n_items++;
      end
    end
    @(negedge clk);
    in_push = 1'b0;

    wait (skinned_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
